FILE: src/lds_pkg.sv
// Package: shared types, codes and constants for the LRU document store.
`timescale 1ns / 1ps

package lds_pkg;

	localparam int DOC_W = 31;
	localparam int ID_W  = 31;
	localparam int RAW_W = 63;
	localparam int CAP_W = 6;

	localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

	// register decode: word index bit of paddr
	localparam logic REG_CAPACITY = 1'b0;

	localparam logic [1:0] OP_QUERY   = 2'd0;
	localparam logic [1:0] OP_PUBLISH = 2'd1;

	localparam logic [3:0] MODE_FWD        = 4'd0;
	localparam logic [3:0] MODE_LINK       = 4'd1;
	localparam logic [3:0] MODE_EXACT      = 4'd2;
	localparam logic [3:0] MODE_PUB_IGNORE = 4'd2;

	localparam logic [1:0] KIND_FWD   = 2'd0;
	localparam logic [1:0] KIND_HIT   = 2'd1;
	localparam logic [1:0] KIND_PUB   = 2'd2;
	localparam logic [1:0] KIND_EVICT = 2'd3;

	typedef struct packed {
		logic [1:0]       op;
		logic [DOC_W-1:0] doc_id;
		logic [ID_W-1:0]  msg_id;
		logic [ID_W-1:0]  peer_id;
		logic [3:0]       mode;
		logic [RAW_W-1:0] raw_message;
	} req_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [DOC_W-1:0] doc_id_out;
		logic [ID_W-1:0]  msg_id_out;
		logic [ID_W-1:0]  peer_id_out;
		logic [RAW_W-1:0] forwarded;
		logic             last;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SHIFT,
		ST_FRONT,
		ST_EMIT_EV,
		ST_EMIT_LAST
	} state_t;

endpackage

FILE: src/lds_mem.sv
// Document id store: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module lds_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [lds_pkg::DOC_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [lds_pkg::DOC_W-1:0] rdata
);

	logic [lds_pkg::DOC_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/lds_apb.sv
// APB register block: the capacity register.
`timescale 1ns / 1ps

module lds_apb (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output logic [lds_pkg::CAP_W-1:0] capacity
);

	logic [lds_pkg::CAP_W-1:0] cap_q;

	assign pready   = 1'b1;
	assign capacity = cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lds_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == lds_pkg::REG_CAPACITY) begin
			cap_q <= pwdata[lds_pkg::CAP_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == lds_pkg::REG_CAPACITY) begin
			prdata = {{(32 - lds_pkg::CAP_W){1'b0}}, cap_q};
		end
	end

endmodule

FILE: src/lru_document_store_match.sv
// Top level: recency-ordered document id set with move-to-front and eviction.
`timescale 1ns / 1ps

// Channel  | Signals                            | Word
// ---------+------------------------------------+-----------------------------
// request  | req_valid, req_stall, req          | lds_pkg::req_t, one item
// response | rsp_valid, rsp_stall, rsp          | lds_pkg::rsp_t, 0..2 per item
// config   | psel/penable/pwrite/paddr/pwdata.. | capacity at byte address 0
//
// A query in link or exact mode scans up to the held count of ids; a publish
// also shifts up to count entries down. Both the scan and the shift are bound
// by the single read port of the store.
// Reset clears the count and the state machine; store contents need no clear.
// A waiting response does not block a new request; the next response waits
// for the output register to free up.

module lru_document_store_match #(
	parameter int MAX_DOCS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  lds_pkg::req_t             req,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output lds_pkg::rsp_t             rsp,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	localparam int AW = (MAX_DOCS > 1) ? $clog2(MAX_DOCS) : 1;
	localparam int CW = $clog2(MAX_DOCS + 1);
	localparam int EW = (CW > lds_pkg::CAP_W) ? CW : lds_pkg::CAP_W;

	lds_pkg::state_t state_q, state_d;

	lds_pkg::req_t             item_q;
	lds_pkg::rsp_t             rsp_q, rsp_d;
	logic                      rsp_valid_q;
	logic                      rsp_load;
	logic [lds_pkg::CAP_W-1:0] capacity;

	logic [CW-1:0]             count_q;
	logic [CW-1:0]             idx_q;
	logic                      pend_s1;
	logic [AW-1:0]             addr_s1;
	logic [AW-1:0]             sh_q;
	logic                      wpend_s1;
	logic [AW-1:0]             waddr_s1;
	logic                      evict_q;
	logic                      emit_q;
	logic [lds_pkg::DOC_W-1:0] ev_q;

	logic                      mem_re;
	logic [AW-1:0]             mem_raddr;
	logic                      mem_we;
	logic [AW-1:0]             mem_waddr;
	logic [lds_pkg::DOC_W-1:0] mem_wdata;
	logic [lds_pkg::DOC_W-1:0] mem_rdata;

	logic                      req_fire;
	logic                      slot_free;
	logic                      req_search;
	logic                      item_pub;
	logic                      hit;
	logic                      miss;
	logic                      evict_c;
	logic [EW-1:0]             eff_cap;
	logic [1:0]                last_kind;

	lds_apb u_apb (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.capacity (capacity)
	);

	lds_mem #(
		.DEPTH (MAX_DOCS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign req_stall = (state_q != lds_pkg::ST_IDLE);
	assign req_fire  = req_valid && !req_stall;
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Only queries in link/exact mode and non-ignored publishes need a scan.
	assign req_search = (req.op == lds_pkg::OP_QUERY
			&& (req.mode == lds_pkg::MODE_LINK || req.mode == lds_pkg::MODE_EXACT))
		|| (req.op == lds_pkg::OP_PUBLISH && req.mode != lds_pkg::MODE_PUB_IGNORE);
	assign item_pub = (item_q.op == lds_pkg::OP_PUBLISH);

	// Scan result: compare the word read last cycle against the item's id.
	assign hit  = (state_q == lds_pkg::ST_SEARCH) && pend_s1 && (mem_rdata == item_q.doc_id);
	assign miss = (state_q == lds_pkg::ST_SEARCH) && !hit && ((count_q == '0)
		|| (pend_s1 && CW'(addr_s1) == count_q - CW'(1)));

	// Capacity of 0 acts as 1, above the store depth acts as the depth.
	always_comb begin
		if (capacity == '0) begin
			eff_cap = EW'(1);
		end else if (EW'(capacity) > EW'(MAX_DOCS)) begin
			eff_cap = EW'(MAX_DOCS);
		end else begin
			eff_cap = EW'(capacity);
		end
	end

	// Insert of a new id overflows: drop the oldest (count stays put).
	assign evict_c = (count_q != '0) && (EW'(count_q) >= eff_cap);

	assign last_kind = !item_pub
		? ((item_q.mode == lds_pkg::MODE_FWD) ? lds_pkg::KIND_FWD : lds_pkg::KIND_HIT)
		: lds_pkg::KIND_PUB;

	// Write port: shift writes land in the cycle after their read; the front
	// write follows the final shift write, so the two never collide.
	assign mem_we    = wpend_s1 || (state_q == lds_pkg::ST_FRONT);
	assign mem_waddr = wpend_s1 ? waddr_s1 : '0;
	assign mem_wdata = wpend_s1 ? mem_rdata : item_q.doc_id;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lds_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_re    = 1'b0;
		mem_raddr = idx_q[AW-1:0];
		rsp_load  = 1'b0;
		rsp_d     = rsp_q;
		case (state_q)
			lds_pkg::ST_IDLE: begin
				if (req_fire) begin
					if (req_search) begin
						state_d = lds_pkg::ST_SEARCH;
					end else if (req.op == lds_pkg::OP_QUERY
							&& req.mode == lds_pkg::MODE_FWD) begin
						state_d = lds_pkg::ST_EMIT_LAST;
					end
				end
			end
			lds_pkg::ST_SEARCH: begin
				if (idx_q < count_q) begin
					mem_re    = 1'b1;
					mem_raddr = idx_q[AW-1:0];
				end
				if (hit) begin
					state_d = item_pub ? lds_pkg::ST_SHIFT : lds_pkg::ST_EMIT_LAST;
				end else if (miss) begin
					state_d = item_pub ? lds_pkg::ST_SHIFT : lds_pkg::ST_IDLE;
				end
			end
			lds_pkg::ST_SHIFT: begin
				if (sh_q != '0) begin
					mem_re    = 1'b1;
					mem_raddr = sh_q - AW'(1);
				end else begin
					state_d = lds_pkg::ST_FRONT;
				end
			end
			lds_pkg::ST_FRONT: begin
				if (!emit_q) begin
					state_d = lds_pkg::ST_IDLE;
				end else if (evict_q) begin
					state_d = lds_pkg::ST_EMIT_EV;
				end else begin
					state_d = lds_pkg::ST_EMIT_LAST;
				end
			end
			lds_pkg::ST_EMIT_EV: begin
				if (slot_free) begin
					rsp_load          = 1'b1;
					rsp_d.kind        = lds_pkg::KIND_EVICT;
					rsp_d.doc_id_out  = ev_q;
					rsp_d.msg_id_out  = '0;
					rsp_d.peer_id_out = item_q.peer_id;
					rsp_d.forwarded   = '0;
					rsp_d.last        = 1'b0;
					state_d           = lds_pkg::ST_EMIT_LAST;
				end
			end
			lds_pkg::ST_EMIT_LAST: begin
				if (slot_free) begin
					rsp_load          = 1'b1;
					rsp_d.kind        = last_kind;
					rsp_d.doc_id_out  = item_q.doc_id;
					rsp_d.msg_id_out  = item_q.msg_id;
					rsp_d.peer_id_out = item_q.peer_id;
					rsp_d.forwarded   = (last_kind == lds_pkg::KIND_FWD)
						? item_q.raw_message : '0;
					rsp_d.last        = 1'b1;
					state_d           = lds_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lds_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			pend_s1     <= 1'b0;
			sh_q        <= '0;
			wpend_s1    <= 1'b0;
			evict_q     <= 1'b0;
			emit_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			wpend_s1 <= (state_q == lds_pkg::ST_SHIFT) && (sh_q != '0);
			if (req_fire) begin
				idx_q   <= '0;
				pend_s1 <= 1'b0;
			end
			if (state_q == lds_pkg::ST_SEARCH) begin
				pend_s1 <= mem_re;
				if (mem_re) begin
					idx_q <= idx_q + CW'(1);
				end
			end
			if (hit) begin
				sh_q    <= addr_s1;
				evict_q <= 1'b0;
				emit_q  <= 1'b0;
			end else if (miss && item_pub) begin
				evict_q <= evict_c;
				emit_q  <= 1'b1;
				if (evict_c) begin
					sh_q <= AW'(count_q - CW'(1));
				end else begin
					sh_q    <= AW'(count_q);
					count_q <= count_q + CW'(1);
				end
			end
			if (state_q == lds_pkg::ST_SHIFT && sh_q != '0) begin
				sh_q <= sh_q - AW'(1);
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (req_fire) begin
			item_q <= req;
		end
		if (state_q == lds_pkg::ST_SEARCH) begin
			addr_s1 <= mem_raddr;
		end
		if (miss) begin
			ev_q <= mem_rdata;
		end
		waddr_s1 <= sh_q;
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

FILE: src/lds_chk.sv
// Port checker for the LRU document store, bound to the top level.
`timescale 1ns / 1ps

module lds_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input lds_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input lds_pkg::rsp_t rsp
);

	// stalled response word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response word changed under stall");

	// only an eviction notice is followed by another word of the same item
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.last == (rsp.kind != lds_pkg::KIND_EVICT)))
		else $error("last flag does not match word kind");

	a_fwd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind != lds_pkg::KIND_FWD |-> rsp.forwarded == '0)
		else $error("forwarded data on a non-forward word");

	a_evict_msg: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == lds_pkg::KIND_EVICT |-> rsp.msg_id_out == '0)
		else $error("eviction notice carries a message id");

	// a real publish always occupies the block for the scan
	a_pub_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.op == lds_pkg::OP_PUBLISH
			&& req.mode != lds_pkg::MODE_PUB_IGNORE |=> req_stall)
		else $error("publish accepted without going busy");

endmodule

bind lru_document_store_match lds_chk u_lds_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
